// ===== hdl/mciir_pkg.sv =====
`default_nettype none

package mciir_pkg;

    // Sizes of the per-channel delay lines.
    localparam int MAX_TAPS     = 8;
    localparam int MAX_CHANNELS = 8;
    localparam int TAP_W        = $clog2(MAX_TAPS);
    localparam int CH_W         = $clog2(MAX_CHANNELS);
    localparam int HIST_DEPTH   = MAX_CHANNELS * MAX_TAPS;
    localparam int HIST_AW      = CH_W + TAP_W;

    // Number formats.
    localparam int SAMPLE_W    = 16;  // Q1.15
    localparam int COEF_W      = 16;  // Q4.12
    localparam int HIST_W      = 24;  // v, 15 fraction bits
    localparam int PROD_W      = COEF_W + HIST_W;
    localparam int ACC_W       = 44;  // 27 fraction bits, headroom for eight products
    localparam int FRAC_SHIFT  = 12;  // 27 - 15 fraction bits
    localparam int ROUND_BIAS  = 2048;

    // Configuration register layout.
    localparam int CFG_W       = 64;
    localparam int CNT_W       = 4;
    localparam int APB_AW      = 6;
    localparam int REG_IDX_W   = APB_AW - 3;
    localparam int NUM_REGS    = 6;
    localparam int COEF_BANK_W = 256 / 2;

    // Register indexes; each register sits at byte address 8 * index.
    localparam logic [REG_IDX_W-1:0] REG_TAP_COUNT     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_FWD_LOW       = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_FWD_HIGH      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FBK_LOW       = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_FBK_HIGH      = 3'd5;

    typedef struct packed {
        logic load;  // load the accumulator with the start value
        logic op;    // a product arrives with this cycle's operands
        logic sub;   // subtract rather than add that product
    } t_mac_ctrl;

    // A count register of zero means one; anything above the maximum is clipped.
    function automatic logic [CNT_W-1:0] count_of(input logic [CNT_W-1:0] cnt,
                                                  input int max_v);
        logic [CNT_W-1:0] res;
        if (cnt == '0) begin
            res = CNT_W'(1);
        end else if (int'(cnt) > max_v) begin
            res = CNT_W'(max_v);
        end else begin
            res = cnt;
        end
        return res;
    endfunction

    // Feedforward coefficient b[idx].
    function automatic logic signed [COEF_W-1:0] coef_fwd(input logic [CFG_W-1:0] lo,
                                                          input logic [CFG_W-1:0] hi,
                                                          input logic [TAP_W-1:0] idx);
        logic [COEF_BANK_W-1:0] bank;
        bank = {hi, lo};
        return bank[COEF_W*idx +: COEF_W];
    endfunction

    // Feedback coefficient a[m], m from one upwards; a1 sits in the lowest word.
    function automatic logic signed [COEF_W-1:0] coef_fbk(input logic [CFG_W-1:0] lo,
                                                          input logic [CFG_W-1:0] hi,
                                                          input logic [TAP_W-1:0] m);
        logic [COEF_BANK_W-1:0] bank;
        logic [TAP_W-1:0]       idx;
        bank = {hi, lo};
        idx  = m - TAP_W'(1);
        return bank[COEF_W*idx +: COEF_W];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/multichannel_iir_df2_filter.sv =====
// Multichannel Direct Form II IIR filter.
// Samples come in on the s_axis channel, interleaved one channel per transfer; the
// block walks channels 0 to channel_count-1 and starts again at 0. Each input
// transfer gives exactly one output transfer on m_axis: the filtered sample in
// tdata, and the channel number and a saturation flag in tuser.
// Tap count, channel count and the b and a coefficients are 64-bit registers at byte
// address 8*i, written through the APB port; the user must write them only while the
// block is idle, which the block itself does not enforce.
// A single multiply-accumulate unit walks the feedback taps, then the feedforward
// taps, with one history read a cycle, and lets the pipeline drain after each walk;
// with a single tap the feedback walk is skipped. The next sample is taken once the
// result has been loaded into the output register, so the result may wait there
// while the next one is computed. If the receiver stalls, the finished result of the
// following sample is held back until the output register has been emptied.
// Reset restores the register defaults (one tap, one channel, b0 = 1.0), clears the
// whole history through per-entry valid bits at once, and returns to channel 0.

`default_nettype none

module multichannel_iir_df2_filter (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Sample stream in.
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [15:0]                         s_axis_tdata,  // [15:0] sample_in
    // Result stream out.
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [15:0]                              m_axis_tdata,  // [15:0] sample_out
    output logic [3:0]                               m_axis_tuser,  // [2:0] channel_index,
                                                                    // [3] saturated
    // Configuration port.
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [mciir_pkg::APB_AW-1:0]        paddr,
    input  wire logic [mciir_pkg::CFG_W-1:0]         pwdata,
    output logic [mciir_pkg::CFG_W-1:0]              prdata,
    output logic                                     pready
);
    import mciir_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_FB      = 7'b0000010,
        S_FB_WAIT = 7'b0000100,
        S_VWR     = 7'b0001000,
        S_FF      = 7'b0010000,
        S_FF_WAIT = 7'b0100000,
        S_OUT     = 7'b1000000
    } t_state;

    // Configuration registers.
    logic [CNT_W-1:0]     r_tap_count;
    logic [CNT_W-1:0]     r_chan_count;
    logic [CFG_W-1:0]     r_fwd_lo;
    logic [CFG_W-1:0]     r_fwd_hi;
    logic [CFG_W-1:0]     r_fbk_lo;
    logic [CFG_W-1:0]     r_fbk_hi;
    logic                 w_cfg_wr;
    logic [REG_IDX_W-1:0] w_cfg_idx;

    // Sequencer state.
    t_state            r_state, n_state;
    logic [TAP_W-1:0]  r_tap, n_tap;
    logic [CH_W-1:0]   r_cur_ch, n_cur_ch;
    logic [TAP_W-1:0]  r_frame_slot, n_frame_slot;
    logic              r_clip, n_clip;
    logic              r_iss_d;
    logic              r_sub_d;
    logic signed [COEF_W-1:0] r_coef_d;

    // Output register.
    logic                r_out_valid, n_out_valid;
    logic [SAMPLE_W-1:0] r_out_sample, n_out_sample;
    logic [2:0]          r_out_ch, n_out_ch;
    logic                r_out_sat, n_out_sat;

    // Datapath wiring.
    logic [CNT_W-1:0]         w_taps;
    logic [CNT_W-1:0]         w_chans;
    logic                     w_accept;
    logic                     w_last_tap;
    logic                     w_issue;
    logic                     w_sub;
    logic signed [COEF_W-1:0] w_coef;
    logic [HIST_AW-1:0]       w_rd_addr;
    logic                     w_wr_en;
    logic [HIST_AW-1:0]       w_wr_addr;
    logic signed [HIST_W-1:0] w_rd_data;
    logic                     w_pipe_busy;
    logic                     w_mac_busy;
    logic                     w_load;
    logic signed [ACC_W-1:0]  w_load_value;
    t_mac_ctrl                w_mac_ctrl;
    logic signed [HIST_W-1:0] w_v;
    logic                     w_v_clip;
    logic signed [SAMPLE_W-1:0] w_y;
    logic                     w_y_clip;

    // ------------------------------------------------------------------
    // Configuration port: writes complete in the access cycle, reads are
    // answered from the addressed register straight away.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_cfg_idx = paddr[APB_AW-1:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count  <= CNT_W'(1);
            r_chan_count <= CNT_W'(1);
            r_fwd_lo     <= CFG_W'(4096);
            r_fwd_hi     <= '0;
            r_fbk_lo     <= '0;
            r_fbk_hi     <= '0;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                REG_TAP_COUNT:     r_tap_count  <= pwdata[CNT_W-1:0];
                REG_CHANNEL_COUNT: r_chan_count <= pwdata[CNT_W-1:0];
                REG_FWD_LOW:       r_fwd_lo     <= pwdata;
                REG_FWD_HIGH:      r_fwd_hi     <= pwdata;
                REG_FBK_LOW:       r_fbk_lo     <= pwdata;
                REG_FBK_HIGH:      r_fbk_hi     <= pwdata;
                default:           ;
            endcase
        end
    end

    always_comb begin
        case (w_cfg_idx)
            REG_TAP_COUNT:     prdata = {{(CFG_W-CNT_W){1'b0}}, r_tap_count};
            REG_CHANNEL_COUNT: prdata = {{(CFG_W-CNT_W){1'b0}}, r_chan_count};
            REG_FWD_LOW:       prdata = r_fwd_lo;
            REG_FWD_HIGH:      prdata = r_fwd_hi;
            REG_FBK_LOW:       prdata = r_fbk_lo;
            REG_FBK_HIGH:      prdata = r_fbk_hi;
            default:           prdata = '0;
        endcase
    end

    assign w_taps  = count_of(r_tap_count, MAX_TAPS);
    assign w_chans = count_of(r_chan_count, MAX_CHANNELS);

    // ------------------------------------------------------------------
    // Sequencer. Feedback taps are issued as subtracting products on top of
    // the scaled input, v is rounded and written back into the current
    // slot, and then the feedforward taps are issued starting at that slot.
    // ------------------------------------------------------------------
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_last_tap    = (CNT_W'(r_tap) == (w_taps - CNT_W'(1)));
    assign w_rd_addr     = {r_cur_ch, r_frame_slot - r_tap};
    assign w_wr_addr     = {r_cur_ch, r_frame_slot};
    assign w_pipe_busy   = r_iss_d || w_mac_busy;

    always_comb begin
        n_state      = r_state;
        n_tap        = r_tap;
        n_cur_ch     = r_cur_ch;
        n_frame_slot = r_frame_slot;
        n_clip       = r_clip;
        w_issue      = 1'b0;
        w_sub        = 1'b0;
        w_coef       = '0;
        w_wr_en      = 1'b0;
        w_load       = 1'b0;
        w_load_value = '0;

        // An untaken result stays; a taken one frees the register.
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_sample = r_out_sample;
        n_out_ch     = r_out_ch;
        n_out_sat    = r_out_sat;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    // A channel count lowered mid-frame closes the frame first.
                    if (CNT_W'(r_cur_ch) >= w_chans) begin
                        n_cur_ch     = '0;
                        n_frame_slot = r_frame_slot + TAP_W'(1);
                    end
                    w_load       = 1'b1;
                    w_load_value = {{(ACC_W-SAMPLE_W-FRAC_SHIFT){s_axis_tdata[SAMPLE_W-1]}},
                                    s_axis_tdata, {FRAC_SHIFT{1'b0}}};
                    n_tap        = TAP_W'(1);
                    n_state      = (w_taps > CNT_W'(1)) ? S_FB : S_FB_WAIT;
                end
            end
            S_FB: begin
                w_issue = 1'b1;
                w_sub   = 1'b1;
                w_coef  = coef_fbk(r_fbk_lo, r_fbk_hi, r_tap);
                if (w_last_tap) begin
                    n_state = S_FB_WAIT;
                end else begin
                    n_tap = r_tap + TAP_W'(1);
                end
            end
            S_FB_WAIT: begin
                if (!w_pipe_busy) begin
                    n_state = S_VWR;
                end
            end
            S_VWR: begin
                w_wr_en      = 1'b1;
                n_clip       = w_v_clip;
                w_load       = 1'b1;
                w_load_value = '0;
                n_tap        = '0;
                n_state      = S_FF;
            end
            S_FF: begin
                w_issue = 1'b1;
                w_coef  = coef_fwd(r_fwd_lo, r_fwd_hi, r_tap);
                if (w_last_tap) begin
                    n_state = S_FF_WAIT;
                end else begin
                    n_tap = r_tap + TAP_W'(1);
                end
            end
            S_FF_WAIT: begin
                if (!w_pipe_busy) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_sample = w_y;
                    n_out_ch     = 3'(r_cur_ch);
                    n_out_sat    = r_clip || w_y_clip;
                    if ((CNT_W'(r_cur_ch) + CNT_W'(1)) >= w_chans) begin
                        n_cur_ch     = '0;
                        n_frame_slot = r_frame_slot + TAP_W'(1);
                    end else begin
                        n_cur_ch = r_cur_ch + CH_W'(1);
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_tap        <= '0;
            r_cur_ch     <= '0;
            r_frame_slot <= '0;
            r_clip       <= 1'b0;
            r_iss_d      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_tap        <= n_tap;
            r_cur_ch     <= n_cur_ch;
            r_frame_slot <= n_frame_slot;
            r_clip       <= n_clip;
            r_iss_d      <= w_issue;
            r_out_valid  <= n_out_valid;
        end
    end

    // The coefficient and direction travel alongside the history read.
    always_ff @(posedge i_clk) begin
        r_coef_d     <= w_coef;
        r_sub_d      <= w_sub;
        r_out_sample <= n_out_sample;
        r_out_ch     <= n_out_ch;
        r_out_sat    <= n_out_sat;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_sample;
    assign m_axis_tuser  = {r_out_sat, r_out_ch};

    // ------------------------------------------------------------------
    // History store and the shared multiply-accumulate unit.
    // ------------------------------------------------------------------
    mciir_hist_ram u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_v),
        .i_rd_en   (w_issue),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_mac_ctrl.load = w_load;
    assign w_mac_ctrl.op   = r_iss_d;
    assign w_mac_ctrl.sub  = r_sub_d;

    mciir_mac u_mac (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_mac_ctrl),
        .i_load_value (w_load_value),
        .i_coef       (r_coef_d),
        .i_data       (w_rd_data),
        .o_busy       (w_mac_busy),
        .o_v          (w_v),
        .o_v_clip     (w_v_clip),
        .o_y          (w_y),
        .o_y_clip     (w_y_clip)
    );

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // A new sample is only taken once the previous one has left the pipeline.
    a_ready_idle_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !w_pipe_busy)
        else $error("input ready while products are still in flight");

    // The sequencer never takes two samples in successive cycles.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !s_axis_tready)
        else $error("second sample accepted straight after the first");

    // Tap walk stays inside the configured tap count.
    a_tap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FB || r_state == S_FF) |-> (CNT_W'(r_tap) < w_taps))
        else $error("tap index beyond the tap count");

    // A result is held back while the output register is still occupied.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && !m_axis_tready) |=> (r_state == S_OUT))
        else $error("result loaded over an untaken result");

endmodule

`default_nettype wire

// ===== hdl/mciir_hist_ram.sv =====
`default_nettype none

module mciir_hist_ram (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_wr_en,
    input  wire logic [mciir_pkg::HIST_AW-1:0]        i_wr_addr,
    input  wire logic signed [mciir_pkg::HIST_W-1:0]  i_wr_data,
    input  wire logic                                 i_rd_en,
    input  wire logic [mciir_pkg::HIST_AW-1:0]        i_rd_addr,
    output logic signed [mciir_pkg::HIST_W-1:0]       o_rd_data
);
    import mciir_pkg::*;

    logic [HIST_W-1:0]     r_mem [HIST_DEPTH];
    logic [HIST_DEPTH-1:0] r_valid;
    logic [HIST_W-1:0]     r_rd_data;
    logic                  r_rd_vld;

    // The store itself has no reset; an entry never written reads as zero.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

`default_nettype wire

// ===== hdl/mciir_mac.sv =====
`default_nettype none

module mciir_mac (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire mciir_pkg::t_mac_ctrl                 i_ctrl,
    input  wire logic signed [mciir_pkg::ACC_W-1:0]   i_load_value,
    input  wire logic signed [mciir_pkg::COEF_W-1:0]  i_coef,
    input  wire logic signed [mciir_pkg::HIST_W-1:0]  i_data,
    output logic                                      o_busy,
    output logic signed [mciir_pkg::HIST_W-1:0]       o_v,
    output logic                                      o_v_clip,
    output logic signed [mciir_pkg::SAMPLE_W-1:0]     o_y,
    output logic                                      o_y_clip
);
    import mciir_pkg::*;

    localparam logic signed [ACC_W-1:0] V_MAX = ACC_W'(2**(HIST_W-1) - 1);
    localparam logic signed [ACC_W-1:0] V_MIN = ~V_MAX;
    localparam logic signed [ACC_W-1:0] Y_MAX = ACC_W'(2**(SAMPLE_W-1) - 1);
    localparam logic signed [ACC_W-1:0] Y_MIN = ~Y_MAX;

    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_vld;
    logic                     r_prod_sub;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  w_prod_ext;
    logic signed [ACC_W-1:0]  w_rnd;
    logic signed [ACC_W-1:0]  w_q;

    assign w_prod = i_coef * i_data;

    // Product stage, then accumulate stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctrl.op;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod     <= w_prod;
        r_prod_sub <= i_ctrl.sub;
    end

    assign w_prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_acc <= i_load_value;
        end else if (r_prod_vld) begin
            r_acc <= r_prod_sub ? (r_acc - w_prod_ext) : (r_acc + w_prod_ext);
        end
    end

    assign o_busy = r_prod_vld;

    // Round half up to 15 fraction bits, then clip to either result width.
    assign w_rnd = r_acc + ACC_W'(ROUND_BIAS);
    assign w_q   = w_rnd >>> FRAC_SHIFT;

    always_comb begin
        o_v_clip = (w_q > V_MAX) || (w_q < V_MIN);
        if (w_q > V_MAX) begin
            o_v = V_MAX[HIST_W-1:0];
        end else if (w_q < V_MIN) begin
            o_v = V_MIN[HIST_W-1:0];
        end else begin
            o_v = w_q[HIST_W-1:0];
        end

        o_y_clip = (w_q > Y_MAX) || (w_q < Y_MIN);
        if (w_q > Y_MAX) begin
            o_y = Y_MAX[SAMPLE_W-1:0];
        end else if (w_q < Y_MIN) begin
            o_y = Y_MIN[SAMPLE_W-1:0];
        end else begin
            o_y = w_q[SAMPLE_W-1:0];
        end
    end

endmodule

`default_nettype wire
